### rtl/core/fwca_pkg.sv
// shared types, constants and helpers for the falling water cell automaton
// no dependencies; imported by every module of the block except fwca_ram
package fwca_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W     = 11;                   // width of a geometry register
    localparam int IDX_W     = 20;                   // cell index on the output
    localparam int POS_W     = 21;                   // input position counter
    localparam int LINE_AW   = $clog2(MAX_WIDTH);    // line buffer address
    localparam int CFG_IDX_W = 8;
    localparam int QDEPTH    = 4;                    // front to back queue
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] RESET_DIM = DIM_W'(256);

    typedef enum logic [2:0] {
        MAT_AIR    = 3'd0,
        MAT_WOOD   = 3'd1,
        MAT_FIRE   = 3'd2,
        MAT_WATER  = 3'd3,
        MAT_BORDER = 3'd4
    } t_cell;

    // one classified item, as queued between front and back
    typedef struct packed {
        t_cell             code;      // material written into the line, or border
        logic              has_res;   // centre cell lies in the grid
        logic              last;      // centre is the final cell of the frame
        logic [IDX_W-1:0]  idx;       // centre cell index
        logic              off_tl;    // upper left neighbour before index 0
        logic              off_t;
        logic              off_tr;
        logic              off_l;
    } t_item;

    typedef struct packed {
        logic [DIM_W-1:0] width;      // clamped row length
        logic             restart;    // geometry written, line pointers restart
    } t_geom;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int hi);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (DIM_W'(hi) < v) begin
            r = DIM_W'(hi);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### rtl/core/fwca_ram.sv
// generic single write port ram with one registered read port
// read during write at the same address returns the old contents
module fwca_ram #(
    parameter  int WIDTH = 3,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fwca_front.sv
// front end: geometry registers, input position tracking and item classification
// depends on fwca_pkg
module fwca_front import fwca_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [1:0]           i_material,
    input  logic                 i_kind,
    input  logic                 i_q_ready,
    output logic                 o_push,
    output t_item                o_item,
    output t_geom                o_geom
);

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [1:0]       r_settle;
    logic [POS_W-1:0] r_total;
    logic [POS_W-1:0] r_last_pos;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;

    logic             cfg_hit;
    logic             accept;
    logic [POS_W-1:0] w_ext;
    logic [POS_W-1:0] wp1;
    logic [POS_W-1:0] w2;
    logic             in_frame;
    t_item            item;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT);

    // derived geometry settles through r_total and then r_last_pos after a write
    assign o_s_tready = (r_settle == 2'd0) && i_q_ready;
    assign accept     = i_s_tvalid && o_s_tready;

    assign w_ext = POS_W'(r_width);
    assign wp1   = w_ext + POS_W'(1);
    assign w2    = {w_ext[POS_W-2:0], 1'b0};

    always_comb begin
        in_frame      = r_pos < r_total;
        item.code     = (in_frame && !i_kind) ? t_cell'({1'b0, i_material}) : MAT_BORDER;
        item.has_res  = (r_pos >= wp1) && (r_pos <= r_last_pos);
        item.last     = r_pos == r_last_pos;
        item.idx      = IDX_W'(r_pos - wp1);
        item.off_tl   = r_pos < w2 + POS_W'(2);
        item.off_t    = r_pos < w2 + POS_W'(1);
        item.off_tr   = r_pos < w2;
        item.off_l    = r_pos == wp1;
        if (item.has_res && item.last) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_DIM;
            r_height <= RESET_DIM;
            r_settle <= 2'd2;
            r_pos    <= '0;
        end else begin
            if (cfg_hit) begin
                if (i_cfg_index == CFG_WIDTH) begin
                    r_width <= clamp_dim(i_cfg_data, MAX_WIDTH);
                end else begin
                    r_height <= clamp_dim(i_cfg_data, MAX_HEIGHT);
                end
                r_settle <= 2'd2;
                r_pos    <= '0;
            end else begin
                if (r_settle != 2'd0) begin
                    r_settle <= r_settle - 2'd1;
                end
                if (accept) begin
                    r_pos <= n_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_total    <= POS_W'(r_width) * POS_W'(r_height);
        r_last_pos <= r_total + w_ext;
    end

    assign o_push         = accept;
    assign o_item         = item;
    assign o_geom.width   = r_width;
    assign o_geom.restart = cfg_hit;

endmodule

### rtl/core/fwca_queue.sv
// short fifo of classified items between the front and back ends
// depends on fwca_pkg
module fwca_queue import fwca_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_not_full,
    input  logic  i_pop,
    output logic  o_not_empty,
    output t_item o_head
);

    t_item              r_entry [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_not_full  = r_count != QCNT_W'(QDEPTH);
    assign o_not_empty = r_count != '0;
    assign o_head      = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/fwca_back.sv
// back end: two line buffers and a 3x3 window over the cell stream, stencil and output register
// depends on fwca_pkg and fwca_ram
module fwca_back import fwca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_geom             i_geom,
    input  logic              i_q_not_empty,
    input  t_item             i_head,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [1:0]        o_next_material,
    output logic [IDX_W-1:0]  o_cell_index,
    output logic              o_last_cell
);

    logic [LINE_AW-1:0] r_ptr_a;
    logic [LINE_AW-1:0] r_ptr_b;
    logic [2:0]         line_a_rd;
    logic [2:0]         line_b_rd;

    // window taps named after their place relative to the centre cell
    t_cell r_br, r_bot, r_bl;     // newest three items
    t_cell r_c, r_l;              // one row back (right tap comes from line a)
    t_cell r_t, r_tl;             // two rows back (upper right from line b)
    t_cell tap_r, tap_tr;
    t_item r_meta;
    logic  r_s1_valid;

    logic  r_out_valid;
    t_cell r_out_mat;
    logic [IDX_W-1:0] r_out_idx;
    logic  r_out_last;

    logic  s1_move;
    logic  pop;
    logic  narrow;
    t_cell nb_t, nb_tr, nb_tl, nb_l;
    t_cell next_mat;

    assign narrow  = i_geom.width == DIM_W'(1);
    assign s1_move = r_s1_valid && (!r_out_valid || i_m_tready);
    assign pop     = i_q_not_empty && (!r_s1_valid || s1_move);
    assign o_pop   = pop;

    // line a delays by one row, line b by one row less one (the window adds the last cell)
    fwca_ram #(.WIDTH(3), .DEPTH(MAX_WIDTH)) u_line_a (
        .i_clk   (i_clk),
        .i_we    (pop),
        .i_waddr (r_ptr_a),
        .i_wdata (i_head.code),
        .i_re    (pop),
        .i_raddr (r_ptr_a),
        .o_rdata (line_a_rd)
    );

    fwca_ram #(.WIDTH(3), .DEPTH(MAX_WIDTH)) u_line_b (
        .i_clk   (i_clk),
        .i_we    (pop),
        .i_waddr (r_ptr_b),
        .i_wdata (line_a_rd),
        .i_re    (pop),
        .i_raddr (r_ptr_b),
        .o_rdata (line_b_rd)
    );

    assign tap_r  = t_cell'(line_a_rd);
    // single-cell rows: two rows back is just two cells back
    assign tap_tr = narrow ? r_c : t_cell'(line_b_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_a <= '0;
            r_ptr_b <= '0;
        end else if (i_geom.restart) begin
            r_ptr_a <= '0;
            r_ptr_b <= '0;
        end else if (pop) begin
            if (r_ptr_a == LINE_AW'(i_geom.width - DIM_W'(1))) begin
                r_ptr_a <= '0;
            end else begin
                r_ptr_a <= r_ptr_a + LINE_AW'(1);
            end
            if (r_ptr_b == LINE_AW'(i_geom.width - DIM_W'(2))) begin
                r_ptr_b <= '0;
            end else begin
                r_ptr_b <= r_ptr_b + LINE_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_br   <= i_head.code;
            r_bot  <= r_br;
            r_bl   <= r_bot;
            r_c    <= tap_r;
            r_l    <= r_c;
            r_t    <= tap_tr;
            r_tl   <= r_t;
            r_meta <= i_head;
        end
    end

    // neighbours before index 0 read as border
    always_comb begin
        nb_t  = r_meta.off_t  ? MAT_BORDER : r_t;
        nb_tl = r_meta.off_tl ? MAT_BORDER : r_tl;
        nb_tr = r_meta.off_tr ? MAT_BORDER : tap_tr;
        nb_l  = r_meta.off_l  ? MAT_BORDER : r_l;
        next_mat = MAT_AIR;
        case (r_c)
            MAT_AIR: begin
                if (nb_t == MAT_WATER) begin
                    next_mat = MAT_WATER;
                end else if (nb_tr == MAT_WATER && tap_r != MAT_AIR && !r_meta.idx[0]) begin
                    next_mat = MAT_WATER;
                end else if (nb_tl == MAT_WATER && nb_l != MAT_AIR && r_meta.idx[0]) begin
                    next_mat = MAT_WATER;
                end
            end
            MAT_WOOD: next_mat = MAT_WOOD;
            MAT_FIRE: next_mat = MAT_FIRE;
            MAT_WATER: begin
                if (r_bot == MAT_AIR || r_bl == MAT_AIR || r_br == MAT_AIR) begin
                    next_mat = MAT_AIR;
                end else begin
                    next_mat = MAT_WATER;
                end
            end
            default: next_mat = MAT_AIR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_s1_valid <= i_head.has_res;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_mat  <= next_mat;
            r_out_idx  <= r_meta.idx;
            r_out_last <= r_meta.last;
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_next_material = r_out_mat[1:0];
    assign o_cell_index    = r_out_idx;
    assign o_last_cell     = r_out_last;

endmodule

### rtl/core/falling_water_cell_automaton.sv
// Falling water automaton, one generation per frame over a raster cell stream. Once the
// derived geometry has settled after reset or a geometry write, one item is taken per cycle
// and the block runs with no stalls of its own, only those from the result side. The result
// for cell j comes out when the item at position j+width+1 has gone in, so a frame must be
// followed by width+1 padding items (tuser high) to flush its last row; results then show
// valid after the queue, window and output registers. Two line buffers of MAX_WIDTH cells,
// one read and one write each per cycle, hold the rows above, and a four-item queue parts
// the classifying front from the stencil so that either side can stall alone.
module falling_water_cell_automaton import fwca_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // geometry writes: index 0 width, index 1 height
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,     // [1:0] material, rest zero
    input  logic                 s_axis_tuser,     // [0] kind (padding when high)
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,     // [1:0] next_material, [21:2] cell_index
    output logic                 m_axis_tlast      // last_cell
);

    logic  q_ready;
    logic  push;
    t_item item;
    t_geom geom;
    logic  q_not_empty;
    logic  pop;
    t_item head;
    logic [1:0]       next_material;
    logic [IDX_W-1:0] cell_index;

    fwca_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_material  (s_axis_tdata[1:0]),
        .i_kind      (s_axis_tuser),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_item      (item),
        .o_geom      (geom)
    );

    fwca_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (item),
        .o_not_full  (q_ready),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_head      (head)
    );

    fwca_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_geom          (geom),
        .i_q_not_empty   (q_not_empty),
        .i_head          (head),
        .o_pop           (pop),
        .o_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .o_next_material (next_material),
        .o_cell_index    (cell_index),
        .o_last_cell     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, cell_index, next_material};

endmodule

### test/falling_water_cell_automaton_test.sv
// self-checking bench for falling_water_cell_automaton: directed and random frames of
// raster cells, each result checked against a behavioural stencil model kept here
// depends on fwca_pkg and the block's top level only
`timescale 1ns / 100ps

module falling_water_cell_automaton_test;
    import fwca_pkg::*;

    localparam int LINE_DEPTH    = 2 * MAX_WIDTH + 3;
    localparam int SETTLE_CYCLES = 16;     // padding may still be in the pipe after the last result
    localparam int MAX_FAULTS_SHOWN = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;

    typedef enum logic [1:0] {
        PLAN_CELL,
        PLAN_GEOM,
        PLAN_DRAIN,
        PLAN_RATES
    } t_plan_op;

    typedef struct {
        t_plan_op             op;
        logic                 kind;
        logic [1:0]           mat;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DIM_W-1:0]     reg_data;
        int                   send_gap;
        int                   recv_gap;
    } t_plan_entry;

    typedef struct packed {
        logic [1:0]       mat;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_cell_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;     // [1:0] material, rest zero
    logic                 s_axis_tuser = 1'b0;   // [0] kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;          // [1:0] next_material, [21:2] cell_index
    logic                 m_axis_tlast;          // last_cell

    falling_water_cell_automaton dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // stencil model state
    t_cell            water_line [LINE_DEPTH];
    int               line_slot;
    logic [POS_W-1:0] in_pos;
    logic [DIM_W-1:0] geom_w;
    logic [DIM_W-1:0] geom_h;
    t_cell_result     due_cells[$];

    // stimulus plan and bookkeeping
    t_plan_entry stream_plan[$];
    int frame_w = 1;
    int frame_h = 1;
    int plan_cells = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int drain_wait = 0;
    int fault_count = 0;
    int results_seen = 0;
    int frames_closed = 0;
    int cells_sent = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("timeout: %0d results still due, %0d plan entries left",
                 due_cells.size(), stream_plan.size());
        $display("Verification failed");
        $finish;
    end

    function automatic int effective_dim(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // material of cell j+d, border off the grid
    function automatic t_cell cell_at(input int j, input int d, input int w, input int total);
        int n;
        int slot;
        n = j + d;
        if (n < 0 || n >= total) return MAT_BORDER;
        slot = (line_slot + LINE_DEPTH - (w + 1 - d)) % LINE_DEPTH;
        return water_line[slot];
    endfunction

    task automatic clear_model();
        for (int i = 0; i < LINE_DEPTH; i++) water_line[i] = MAT_BORDER;
        line_slot = 0;
        in_pos = '0;
        geom_w = RESET_DIM;
        geom_h = RESET_DIM;
    endtask

    task automatic write_geometry(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        if (idx == CFG_WIDTH) begin
            geom_w = data;
        end else if (idx == CFG_HEIGHT) begin
            geom_h = data;
        end else begin
            return;
        end
        in_pos = '0;
    endtask

    task automatic advance_cell(input logic kind, input logic [1:0] mat);
        int w, h, total, p, j;
        t_cell centre, grown;
        t_cell_result res;
        w = effective_dim(geom_w, MAX_WIDTH);
        h = effective_dim(geom_h, MAX_HEIGHT);
        total = w * h;
        p = int'(in_pos);
        line_slot = (line_slot + 1) % LINE_DEPTH;
        if (p < total && !kind) begin
            water_line[line_slot] = t_cell'({1'b0, mat});
        end else begin
            water_line[line_slot] = MAT_BORDER;
        end
        in_pos = in_pos + 1'b1;
        j = p - (w + 1);
        if (j < 0 || j >= total) return;

        centre = cell_at(j, 0, w, total);
        grown = MAT_AIR;
        case (centre)
            MAT_AIR: begin
                // falls from above, or spreads sideways over a blocked cell by index parity
                if (cell_at(j, -w, w, total) == MAT_WATER) begin
                    grown = MAT_WATER;
                end else if (cell_at(j, 1 - w, w, total) == MAT_WATER &&
                             cell_at(j, 1, w, total) != MAT_AIR && (j % 2) == 0) begin
                    grown = MAT_WATER;
                end else if (cell_at(j, -1 - w, w, total) == MAT_WATER &&
                             cell_at(j, -1, w, total) != MAT_AIR && (j % 2) == 1) begin
                    grown = MAT_WATER;
                end
            end
            MAT_WOOD, MAT_FIRE: begin
                grown = centre;
            end
            MAT_WATER: begin
                if (cell_at(j, w, w, total) == MAT_AIR ||
                    cell_at(j, w - 1, w, total) == MAT_AIR ||
                    cell_at(j, w + 1, w, total) == MAT_AIR) begin
                    grown = MAT_AIR;
                end else begin
                    grown = MAT_WATER;
                end
            end
            default: begin
                grown = MAT_AIR;
            end
        endcase

        res.mat = grown[1:0];
        res.idx = IDX_W'(j);
        res.last = (j == total - 1);
        due_cells.push_back(res);
        if (res.last) in_pos = '0;
    endtask

    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_FAULTS_SHOWN) $display("%0t: %s", $time, msg);
    endtask

    // plan builders
    function automatic logic [1:0] pick_material();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 2'(MAT_AIR);
        if (r < 70) return 2'(MAT_WATER);
        if (r < 85) return 2'(MAT_WOOD);
        return 2'(MAT_FIRE);
    endfunction

    task automatic push_cell(input logic kind, input logic [1:0] mat);
        t_plan_entry e;
        e = '{op: PLAN_CELL, kind: kind, mat: mat, reg_idx: '0, reg_data: '0,
              send_gap: 0, recv_gap: 0};
        stream_plan.push_back(e);
        plan_cells++;
    endtask

    task automatic push_drain();
        t_plan_entry e;
        e = '{op: PLAN_DRAIN, kind: 1'b0, mat: '0, reg_idx: '0, reg_data: '0,
              send_gap: 0, recv_gap: 0};
        stream_plan.push_back(e);
    endtask

    task automatic plan_geometry(input int wr, input int hr);
        t_plan_entry e;
        push_drain();
        e = '{op: PLAN_GEOM, kind: 1'b0, mat: '0, reg_idx: CFG_UNUSED,
              reg_data: DIM_W'($urandom_range(2047)), send_gap: 0, recv_gap: 0};
        if ($urandom_range(99) < 10) stream_plan.push_back(e);
        e.reg_idx = CFG_WIDTH;
        e.reg_data = DIM_W'(wr);
        stream_plan.push_back(e);
        e.reg_idx = CFG_HEIGHT;
        e.reg_data = DIM_W'(hr);
        stream_plan.push_back(e);
        frame_w = effective_dim(wr, MAX_WIDTH);
        frame_h = effective_dim(hr, MAX_HEIGHT);
    endtask

    // one frame of random cells plus its flush, cut short if cut >= 0
    task automatic push_frame(input int cut, input int pause);
        int total, count;
        total = frame_w * frame_h;
        count = (cut >= 0) ? cut : total + frame_w + 1;
        for (int p = 0; p < count; p++) begin
            if (p == pause) push_drain();
            if (p < total) begin
                push_cell($urandom_range(99) < 3, pick_material());
            end else begin
                push_cell($urandom_range(99) < 85, 2'($urandom_range(3)));
            end
        end
    endtask

    // driver: plays the plan, predicts each item when it is taken
    always @(posedge i_clk) begin
        logic launch_cell;
        logic launch_geom;
        logic stalled;
        t_plan_entry head;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            i_cfg_valid   <= 1'b0;
            i_cfg_index   <= '0;
            i_cfg_data    <= '0;
            clear_model();
            drain_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_cell(s_axis_tuser, s_axis_tdata[1:0]);
                cells_sent++;
            end
            if (i_cfg_valid && o_cfg_ready) write_geometry(i_cfg_index, i_cfg_data);
            stalled = (s_axis_tvalid && !s_axis_tready) || (i_cfg_valid && !o_cfg_ready);
            launch_cell = 1'b0;
            launch_geom = 1'b0;
            if (!stalled) begin
                while (stream_plan.size() != 0 && stream_plan[0].op == PLAN_RATES) begin
                    send_gap = stream_plan[0].send_gap;
                    recv_gap = stream_plan[0].recv_gap;
                    stream_plan.delete(0);
                end
                if (stream_plan.size() != 0) begin
                    head = stream_plan[0];
                    case (head.op)
                        PLAN_DRAIN: begin
                            drain_wait = (due_cells.size() == 0) ? drain_wait + 1 : 0;
                            if (drain_wait >= SETTLE_CYCLES) begin
                                drain_wait = 0;
                                stream_plan.delete(0);
                            end
                        end
                        PLAN_GEOM: begin
                            launch_geom = 1'b1;
                            stream_plan.delete(0);
                        end
                        default: begin
                            if ($urandom_range(99) >= send_gap) begin
                                launch_cell = 1'b1;
                                stream_plan.delete(0);
                            end
                        end
                    endcase
                end
                s_axis_tvalid <= launch_cell;
                i_cfg_valid   <= launch_geom;
                if (launch_cell) begin
                    s_axis_tdata <= {6'b0, head.mat};
                    s_axis_tuser <= head.kind;
                end
                if (launch_geom) begin
                    i_cfg_index <= head.reg_idx;
                    i_cfg_data  <= head.reg_data;
                end
            end
        end
    end

    // monitor: checks each result against the oldest prediction
    always @(posedge i_clk) begin
        t_cell_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tlast) frames_closed++;
                if (due_cells.size() == 0) begin
                    log_fault($sformatf("result with nothing due: mat %0d idx %0d last %0b",
                                        m_axis_tdata[1:0], m_axis_tdata[21:2], m_axis_tlast));
                end else begin
                    want = due_cells.pop_front();
                    if (m_axis_tdata[1:0] !== want.mat || m_axis_tdata[21:2] !== want.idx ||
                        m_axis_tlast !== want.last) begin
                        log_fault($sformatf(
                            "mismatch: expected mat %0d idx %0d last %0b, got mat %0d idx %0d last %0b",
                            want.mat, want.idx, want.last,
                            m_axis_tdata[1:0], m_axis_tdata[21:2], m_axis_tlast));
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_gap);
        end
    end

    initial begin
        t_plan_entry e;
        int phase_target;
        int guard;
        int full, cut, pause;
        logic restart_due;

        // directed: 4x3 frame with both parity spreads and padding in the grid
        e = '{op: PLAN_GEOM, kind: 1'b0, mat: '0, reg_idx: CFG_UNUSED, reg_data: '1,
              send_gap: 0, recv_gap: 0};
        stream_plan.push_back(e);
        plan_geometry(4, 3);
        push_cell(1'b0, 2'(MAT_AIR));
        push_cell(1'b0, 2'(MAT_WATER));
        push_cell(1'b0, 2'(MAT_WATER));
        push_cell(1'b1, 2'(MAT_WATER));
        push_cell(1'b0, 2'(MAT_AIR));
        push_cell(1'b0, 2'(MAT_WOOD));
        push_cell(1'b0, 2'(MAT_FIRE));
        push_cell(1'b0, 2'(MAT_AIR));
        push_cell(1'b0, 2'(MAT_WATER));
        push_cell(1'b0, 2'(MAT_WATER));
        push_cell(1'b0, 2'(MAT_AIR));
        push_cell(1'b0, 2'(MAT_WATER));
        push_cell(1'b1, 2'(MAT_AIR));
        push_cell(1'b0, 2'(MAT_WATER));
        push_cell(1'b1, 2'(MAT_WATER));
        push_cell(1'b1, 2'(MAT_FIRE));
        push_cell(1'b1, 2'(MAT_WOOD));
        // zero geometry acts as a single cell, two frames back to back
        plan_geometry(0, 0);
        push_cell(1'b0, 2'(MAT_WATER));
        push_cell(1'b1, 2'(MAT_AIR));
        push_cell(1'b0, 2'(MAT_AIR));
        push_cell(1'b0, 2'(MAT_AIR));
        push_cell(1'b1, 2'(MAT_WATER));
        push_cell(1'b1, 2'(MAT_FIRE));

        restart_due = 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            e = '{op: PLAN_RATES, kind: 1'b0, mat: '0, reg_idx: '0, reg_data: '0,
                  send_gap: (phase == 0) ? 7 : (phase == 1) ? 58 : 0,
                  recv_gap: (phase == 0) ? 58 : (phase == 1) ? 7 : 0};
            stream_plan.push_back(e);
            if (phase == 1) begin
                // widest geometry, clamped, started but never finished
                plan_geometry(2047, 2047);
                push_frame(1060, -1);
                restart_due = 1'b1;
            end else if (phase == 2) begin
                // tall single column, with the sender held until all results are back
                plan_geometry(1, 1024);
                push_frame(60, 30);
                restart_due = 1'b1;
            end
            phase_target = plan_cells + 200;
            while (plan_cells < phase_target) begin
                if (restart_due || $urandom_range(99) < 60) begin
                    if ($urandom_range(99) < 85) begin
                        plan_geometry($urandom_range(1, 12), $urandom_range(1, 8));
                    end else begin
                        plan_geometry($urandom_range(13, 64), $urandom_range(1, 4));
                    end
                    restart_due = 1'b0;
                end
                full = frame_w * frame_h + frame_w + 1;
                cut = ($urandom_range(99) < 10) ? $urandom_range(1, full - 1) : -1;
                pause = ($urandom_range(99) < 5) ? $urandom_range(0, full - 1) : -1;
                push_frame(cut, pause);
                if (cut >= 0) begin
                    restart_due = 1'b1;
                end else if ($urandom_range(99) < 5) begin
                    // stray items after a frame open a new one of their own
                    repeat ($urandom_range(1, 3)) push_cell(1'($urandom_range(1)), pick_material());
                    restart_due = 1'b1;
                end
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stream_plan.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (s_axis_tvalid || i_cfg_valid) @(posedge i_clk);
        guard = 0;
        while (due_cells.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (due_cells.size() != 0) begin
            log_fault($sformatf("%0d predicted results never came out", due_cells.size()));
        end

        $display("sent %0d cells and padding items, checked %0d results over %0d closed frames",
                 cells_sent, results_seen, frames_closed);
        $display("geometries from a single cell up to clamped 1024-wide rows, %0d faults",
                 fault_count);
        if (fault_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
